// ===== design/bcf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block-tridiagonal Cholesky forward sweep: shared package
// Item formats, sequencer state types, storage region map, unit handshake
// structs and the saturation helper.
// ----------------------------------------------------------------------------
package bcf_pkg;

  localparam int BLOCK_DIM_DEF = 4;
  localparam int DATA_W        = 32;
  localparam int FRAC_W        = 16;
  localparam int PROD_W        = 48;
  localparam int ACC_W         = 56;
  localparam int IDX_W         = 2;

  // Request codes.
  localparam logic [1:0] REQ_COUPLING  = 2'd0;
  localparam logic [1:0] REQ_PRECISION = 2'd1;
  localparam logic [1:0] REQ_RHS       = 2'd2;
  localparam logic [1:0] REQ_RESTART   = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_FACTOR = 2'd0;
  localparam logic [1:0] KIND_LO     = 2'd1;
  localparam logic [1:0] KIND_MEAN   = 2'd2;

  // Storage regions, each BLOCK_DIM*BLOCK_DIM entries. The two cleared
  // regions come first so that their valid bits cover the lowest addresses.
  localparam int REG_O      = 0;
  localparam int REG_V      = 1;
  localparam int REG_C      = 2;
  localparam int REG_L      = 3;
  localparam int REG_LO     = 4;
  localparam int REG_Y      = 5;
  localparam int REG_M      = 6;
  localparam int REGION_CNT = 7;
  localparam int CLEAR_REGIONS = 2;

  typedef struct packed {
    logic [1:0]              req_type;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [DATA_W-1:0] element_value;
    logic                    compute_now;
  } item_t;

  typedef struct packed {
    logic [1:0]              result_kind;
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [DATA_W-1:0] result_value;
    logic                    pivot_error;
    logic                    last_of_run;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BASE,
    ST_BCAP,
    ST_TERM_RD,
    ST_TERM_MUL,
    ST_TERM_ACC,
    ST_POST,
    ST_UNIT,
    ST_EM_RD,
    ST_EM_LD
  } st_t;

  typedef enum logic [3:0] {
    PH_UPO,
    PH_UPC,
    PH_DIAG,
    PH_OFF,
    PH_LO,
    PH_Y,
    PH_M,
    PH_EML,
    PH_EMLO,
    PH_EMM
  } ph_t;

  typedef struct packed {
    logic                     start;
    logic                     is_sqrt;
    logic signed [DATA_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } unit_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] value;
  } unit_rsp_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(64'sd2147483647);
    lo = ACC_W'(-64'sd2147483648);
    if (v > hi) return 32'sh7fffffff;
    if (v < lo) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

endpackage

// ===== design/bcf_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block-tridiagonal Cholesky forward sweep: working store
// One write port and two registered read ports. The lowest entries carry
// valid bits so that the precision block and the right-hand vector read as
// zero until loaded and can all be cleared at once.
// ----------------------------------------------------------------------------
module bcf_mem import bcf_pkg::*; #(
  parameter int DEPTH = REGION_CNT * BLOCK_DIM_DEF * BLOCK_DIM_DEF,
  parameter int VSPAN = CLEAR_REGIONS * BLOCK_DIM_DEF * BLOCK_DIM_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int VW = (VSPAN > 1) ? $clog2(VSPAN) : 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              clear,
  input  logic              re0,
  input  logic [AW-1:0]     raddr0,
  output logic [DATA_W-1:0] rdata0,
  input  logic              re1,
  input  logic [AW-1:0]     raddr1,
  output logic [DATA_W-1:0] rdata1
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [VSPAN-1:0]  valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (clear) begin
        valid <= '0;
      end
      if (we && (int'(waddr) < VSPAN)) begin
        valid[waddr[VW-1:0]] <= 1'b1;
      end
    end
  end

  // An entry of a cleared region that was not loaded reads as zero.
  always_ff @(posedge clk) begin
    if (re0) begin
      if ((int'(raddr0) < VSPAN) && !valid[raddr0[VW-1:0]]) begin
        rdata0 <= '0;
      end else begin
        rdata0 <= mem[raddr0];
      end
    end
    if (re1) begin
      if ((int'(raddr1) < VSPAN) && !valid[raddr1[VW-1:0]]) begin
        rdata1 <= '0;
      end else begin
        rdata1 <= mem[raddr1];
      end
    end
  end

endmodule

// ===== design/bcf_divsqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block-tridiagonal Cholesky forward sweep: divide and square-root unit
// Radix-2 restoring divider for (a * 2^16) / b and a digit-by-digit square
// root of a * 2^16, one bit per cycle, sharing one control counter.
// ----------------------------------------------------------------------------
module bcf_divsqrt import bcf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  unit_req_t req,
  output unit_rsp_t rsp
);

  localparam int NW         = DATA_W + FRAC_W;
  localparam int DIV_STEPS  = NW;
  localparam int SQRT_STEPS = NW / 2;
  localparam int CNT_W      = $clog2(DIV_STEPS + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  cnt;
  logic              is_sqrt;
  logic              neg;
  logic [DATA_W-1:0] dmag;
  logic [DATA_W:0]   rem;
  logic [NW-1:0]     num;
  logic [NW-1:0]     quo;
  logic [NW-1:0]     sx;
  logic [NW-1:0]     rt;
  logic [NW-1:0]     bitv;

  logic [DATA_W:0]         rem_sh;
  logic                    ge;
  logic [DATA_W:0]         rem_nx;
  logic [NW-1:0]           sum;
  logic                    take;
  logic signed [ACC_W-1:0] qext;
  logic signed [ACC_W-1:0] qs;

  function automatic logic [DATA_W-1:0] mag(input logic signed [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
  endfunction

  always_comb begin
    rem_sh = {rem[DATA_W-1:0], num[NW-1]};
    ge     = rem_sh >= {1'b0, dmag};
    rem_nx = ge ? (rem_sh - {1'b0, dmag}) : rem_sh;
    sum    = rt + bitv;
    take   = sx >= sum;
    qext   = ACC_W'({1'b0, quo});
    qs     = neg ? -qext : qext;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.is_sqrt ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      is_sqrt <= req.is_sqrt;
      neg     <= req.num[DATA_W-1] ^ req.den[DATA_W-1];
      dmag    <= mag(req.den);
      num     <= {mag(req.num), FRAC_W'(0)};
      rem     <= '0;
      quo     <= '0;
      sx      <= {req.num, FRAC_W'(0)};
      rt      <= '0;
      bitv    <= NW'(1) << (NW - 2);
    end else if (busy) begin
      if (is_sqrt) begin
        sx   <= take ? (sx - sum) : sx;
        rt   <= take ? ((rt >> 1) + bitv) : (rt >> 1);
        bitv <= bitv >> 2;
      end else begin
        rem <= rem_nx;
        num <= num << 1;
        quo <= {quo[NW-2:0], ge};
      end
    end
  end

  always_comb begin
    rsp.done  = done;
    rsp.value = is_sqrt ? rt[DATA_W-1:0] : sat32(qs);
  end

endmodule

// ===== design/bcf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block-tridiagonal Cholesky forward sweep: sequencer
// Takes load items, walks the update, factor and solve loops one entry at a
// time through the working store with one multiply-accumulate path, hands
// roots and quotients to the shared unit and emits the results.
// ----------------------------------------------------------------------------
module bcf_ctrl import bcf_pkg::*; #(
  parameter int BLOCK_DIM = BLOCK_DIM_DEF,
  localparam int NN = BLOCK_DIM * BLOCK_DIM,
  localparam int AW = $clog2(REGION_CNT * NN)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  output logic              mem_we,
  output logic [AW-1:0]     mem_waddr,
  output logic [DATA_W-1:0] mem_wdata,
  output logic              mem_clear,
  output logic              mem_re0,
  output logic [AW-1:0]     mem_raddr0,
  input  logic [DATA_W-1:0] mem_rdata0,
  output logic              mem_re1,
  output logic [AW-1:0]     mem_raddr1,
  input  logic [DATA_W-1:0] mem_rdata1,
  output unit_req_t         ureq,
  input  unit_rsp_t         ursp
);

  localparam int CW = $clog2(BLOCK_DIM + 1);
  localparam logic [CW-1:0] LAST = CW'(BLOCK_DIM - 1);
  localparam logic [CW-1:0] ZERO = CW'(0);

  st_t st, st_next;
  ph_t ph, ph_next;
  logic [CW-1:0] i, i_next, j, j_next, k, k_next;
  logic first_step, first_step_next;
  logic err, err_next;
  logic signed [ACC_W-1:0]  acc, acc_next;
  logic signed [DATA_W-1:0] dv, dv_next;
  logic signed [PROD_W-1:0] prod;

  logic [AW-1:0] base_a, div_a, a_a, b_a, dst_a, emit_a;
  logic [CW-1:0] kst, kend;
  ph_t           adv_ph;
  logic [CW-1:0] adv_i, adv_j;
  logic          adv_done;
  logic          do_adv;
  logic          load_res;
  logic          restart;
  logic signed [DATA_W-1:0] t;

  function automatic logic [AW-1:0] addr_of(input int region, input int r, input int c);
    return AW'(region * NN + r * BLOCK_DIM + c);
  endfunction

  function automatic logic signed [PROD_W-1:0] mulq(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [2*DATA_W-1:0] p;
    p = a * b;
    return PROD_W'((p + 64'sd32768) >>> FRAC_W);
  endfunction

  assign t       = sat32(acc);
  assign restart = item.req_type == REQ_RESTART;

  // Operand, divisor and destination addresses of the current entry.
  always_comb begin
    base_a = '0;
    div_a  = '0;
    a_a    = '0;
    b_a    = '0;
    dst_a  = '0;
    emit_a = '0;
    kst    = ZERO;
    kend   = ZERO;
    unique case (ph)
      PH_UPO: begin
        base_a = addr_of(REG_O, int'(i), int'(j));
        a_a    = addr_of(REG_LO, int'(k), int'(i));
        b_a    = addr_of(REG_LO, int'(k), int'(j));
        dst_a  = base_a;
        kend   = CW'(BLOCK_DIM);
      end
      PH_UPC: begin
        base_a = addr_of(REG_V, int'(i), 0);
        a_a    = addr_of(REG_C, int'(i), int'(k));
        b_a    = addr_of(REG_M, int'(k), 0);
        dst_a  = base_a;
        kend   = CW'(BLOCK_DIM);
      end
      PH_DIAG: begin
        base_a = addr_of(REG_O, int'(j), int'(j));
        a_a    = addr_of(REG_L, int'(j), int'(k));
        b_a    = a_a;
        dst_a  = addr_of(REG_L, int'(j), int'(j));
        kend   = j;
      end
      PH_OFF: begin
        base_a = addr_of(REG_O, int'(i), int'(j));
        div_a  = addr_of(REG_L, int'(j), int'(j));
        a_a    = addr_of(REG_L, int'(i), int'(k));
        b_a    = addr_of(REG_L, int'(j), int'(k));
        dst_a  = addr_of(REG_L, int'(i), int'(j));
        kend   = j;
      end
      PH_LO: begin
        base_a = addr_of(REG_C, int'(i), int'(j));
        div_a  = addr_of(REG_L, int'(i), int'(i));
        a_a    = addr_of(REG_L, int'(i), int'(k));
        b_a    = addr_of(REG_LO, int'(k), int'(j));
        dst_a  = addr_of(REG_LO, int'(i), int'(j));
        kend   = i;
      end
      PH_Y: begin
        base_a = addr_of(REG_V, int'(i), 0);
        div_a  = addr_of(REG_L, int'(i), int'(i));
        a_a    = addr_of(REG_L, int'(i), int'(k));
        b_a    = addr_of(REG_Y, int'(k), 0);
        dst_a  = addr_of(REG_Y, int'(i), 0);
        kend   = i;
      end
      PH_M: begin
        base_a = addr_of(REG_Y, int'(i), 0);
        div_a  = addr_of(REG_L, int'(i), int'(i));
        a_a    = addr_of(REG_L, int'(k), int'(i));
        b_a    = addr_of(REG_M, int'(k), 0);
        dst_a  = addr_of(REG_M, int'(i), 0);
        kst    = CW'(i + 1'b1);
        kend   = CW'(BLOCK_DIM);
      end
      PH_EML:  emit_a = addr_of(REG_L, int'(i), int'(j));
      PH_EMLO: emit_a = addr_of(REG_LO, int'(i), int'(j));
      PH_EMM:  emit_a = addr_of(REG_M, int'(i), 0);
      default: ;
    endcase
  end

  // Loop order: which entry comes after the current one.
  always_comb begin
    adv_ph   = ph;
    adv_i    = i;
    adv_j    = j;
    adv_done = 1'b0;
    unique case (ph)
      PH_UPO: begin
        if (j < i) adv_j = CW'(j + 1'b1);
        else adv_ph = PH_UPC;
      end
      PH_UPC: begin
        if (i < LAST) begin
          adv_ph = PH_UPO;
          adv_i  = CW'(i + 1'b1);
          adv_j  = ZERO;
        end else begin
          adv_ph = PH_DIAG;
          adv_j  = ZERO;
        end
      end
      PH_DIAG: begin
        if (j < LAST) begin
          adv_ph = PH_OFF;
          adv_i  = CW'(j + 1'b1);
        end else begin
          adv_ph = PH_LO;
          adv_i  = ZERO;
          adv_j  = ZERO;
        end
      end
      PH_OFF: begin
        if (i < LAST) begin
          adv_i = CW'(i + 1'b1);
        end else begin
          adv_ph = PH_DIAG;
          adv_j  = CW'(j + 1'b1);
        end
      end
      PH_LO: begin
        if (i < LAST) begin
          adv_i = CW'(i + 1'b1);
        end else if (j < LAST) begin
          adv_i = ZERO;
          adv_j = CW'(j + 1'b1);
        end else begin
          adv_ph = PH_Y;
          adv_i  = ZERO;
        end
      end
      PH_Y: begin
        if (i < LAST) begin
          adv_i = CW'(i + 1'b1);
        end else begin
          adv_ph = PH_M;
          adv_i  = LAST;
        end
      end
      PH_M: begin
        if (i != ZERO) begin
          adv_i = CW'(i - 1'b1);
        end else begin
          adv_ph = PH_EML;
          adv_i  = ZERO;
          adv_j  = ZERO;
        end
      end
      PH_EML: begin
        if (j < i) begin
          adv_j = CW'(j + 1'b1);
        end else if (i < LAST) begin
          adv_i = CW'(i + 1'b1);
          adv_j = ZERO;
        end else begin
          adv_ph = PH_EMLO;
          adv_i  = ZERO;
          adv_j  = ZERO;
        end
      end
      PH_EMLO: begin
        if (j < LAST) begin
          adv_j = CW'(j + 1'b1);
        end else if (i < LAST) begin
          adv_i = CW'(i + 1'b1);
          adv_j = ZERO;
        end else begin
          adv_ph = PH_EMM;
          adv_i  = ZERO;
          adv_j  = ZERO;
        end
      end
      PH_EMM: begin
        if (i < LAST) adv_i = CW'(i + 1'b1);
        else adv_done = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_next         = st;
    ph_next         = ph;
    i_next          = i;
    j_next          = j;
    k_next          = k;
    first_step_next = first_step;
    err_next        = err;
    acc_next        = acc;
    dv_next         = dv;
    mem_we          = 1'b0;
    mem_waddr       = dst_a;
    mem_wdata       = t;
    mem_clear       = 1'b0;
    mem_re0         = 1'b0;
    mem_raddr0      = base_a;
    mem_re1         = 1'b0;
    mem_raddr1      = div_a;
    ureq            = '0;
    ureq.num        = t;
    ureq.den        = dv;
    do_adv          = 1'b0;
    load_res        = 1'b0;
    item_stall      = (st != ST_IDLE);
    unique case (st)
      ST_IDLE: begin
        if (item_valid) begin
          mem_wdata = item.element_value;
          priority if (item.req_type == REQ_COUPLING) begin
            mem_we    = (int'(item.row_index) < BLOCK_DIM) && (int'(item.col_index) < BLOCK_DIM);
            mem_waddr = addr_of(REG_C, int'(item.row_index), int'(item.col_index));
          end else if (item.req_type == REQ_PRECISION) begin
            mem_we    = (int'(item.row_index) < BLOCK_DIM) && (int'(item.col_index) < BLOCK_DIM);
            mem_waddr = addr_of(REG_O, int'(item.row_index), int'(item.col_index));
          end else if (item.req_type == REQ_RHS) begin
            mem_we    = int'(item.row_index) < BLOCK_DIM;
            mem_waddr = addr_of(REG_V, int'(item.row_index), 0);
          end else begin
            first_step_next = 1'b1;
          end
          if (item.compute_now) begin
            err_next = 1'b0;
            st_next  = ST_BASE;
            i_next   = ZERO;
            j_next   = ZERO;
            ph_next  = (first_step || restart) ? PH_DIAG : PH_UPO;
          end
        end
      end
      ST_BASE: begin
        mem_re0 = 1'b1;
        mem_re1 = 1'b1;
        st_next = ST_BCAP;
      end
      ST_BCAP: begin
        acc_next = ACC_W'($signed(mem_rdata0));
        dv_next  = $signed(mem_rdata1);
        k_next   = kst;
        st_next  = (kst < kend) ? ST_TERM_RD : ST_POST;
      end
      ST_TERM_RD: begin
        mem_re0    = 1'b1;
        mem_re1    = 1'b1;
        mem_raddr0 = a_a;
        mem_raddr1 = b_a;
        st_next    = ST_TERM_MUL;
      end
      ST_TERM_MUL: begin
        st_next = ST_TERM_ACC;
      end
      ST_TERM_ACC: begin
        acc_next = acc - ACC_W'(prod);
        if (CW'(k + 1'b1) < kend) begin
          k_next  = CW'(k + 1'b1);
          st_next = ST_TERM_RD;
        end else begin
          st_next = ST_POST;
        end
      end
      ST_POST: begin
        priority if (ph == PH_UPO || ph == PH_UPC) begin
          mem_we = 1'b1;
          do_adv = 1'b1;
        end else if (ph == PH_DIAG) begin
          if (t <= 32'sd0) begin
            // Non-positive pivot: flag it and store a zero diagonal.
            err_next  = 1'b1;
            mem_we    = 1'b1;
            mem_wdata = '0;
            do_adv    = 1'b1;
          end else begin
            ureq.start   = 1'b1;
            ureq.is_sqrt = 1'b1;
            st_next      = ST_UNIT;
          end
        end else begin
          if (dv == 32'sd0) begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            do_adv    = 1'b1;
          end else begin
            ureq.start = 1'b1;
            st_next    = ST_UNIT;
          end
        end
      end
      ST_UNIT: begin
        if (ursp.done) begin
          mem_we    = 1'b1;
          mem_wdata = ursp.value;
          do_adv    = 1'b1;
        end
      end
      ST_EM_RD: begin
        mem_re0    = 1'b1;
        mem_raddr0 = emit_a;
        st_next    = ST_EM_LD;
      end
      ST_EM_LD: begin
        if (!result_valid || !result_stall) begin
          load_res = 1'b1;
          if (adv_done) begin
            st_next = ST_IDLE;
          end else begin
            ph_next = adv_ph;
            i_next  = adv_i;
            j_next  = adv_j;
            st_next = ST_EM_RD;
          end
        end
      end
      default: st_next = ST_IDLE;
    endcase

    if (do_adv) begin
      ph_next = adv_ph;
      i_next  = adv_i;
      j_next  = adv_j;
      if (adv_ph == PH_EML) begin
        // The loads of this step are used up once the solves are done.
        st_next         = ST_EM_RD;
        mem_clear       = 1'b1;
        first_step_next = 1'b0;
      end else begin
        st_next = ST_BASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      ph           <= PH_UPO;
      i            <= '0;
      j            <= '0;
      k            <= '0;
      first_step   <= 1'b1;
      err          <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      st         <= st_next;
      ph         <= ph_next;
      i          <= i_next;
      j          <= j_next;
      k          <= k_next;
      first_step <= first_step_next;
      err        <= err_next;
      if (load_res) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc  <= acc_next;
    dv   <= dv_next;
    prod <= mulq($signed(mem_rdata0), $signed(mem_rdata1));
    if (load_res) begin
      result.result_kind  <= (ph == PH_EML) ? KIND_FACTOR :
                             (ph == PH_EMLO) ? KIND_LO : KIND_MEAN;
      result.out_row      <= IDX_W'(i);
      result.out_col      <= (ph == PH_EMM) ? '0 : IDX_W'(j);
      result.result_value <= $signed(mem_rdata0);
      result.pivot_error  <= err;
      result.last_of_run  <= adv_done;
    end
  end

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !(mem_re0 || mem_re1))
    else $error("store write collides with a read");

  a_unit_start: assert property (@(posedge clk) disable iff (rst)
    ureq.start |-> (st == ST_POST))
    else $error("unit started outside the post step");

  a_unit_done: assert property (@(posedge clk) disable iff (rst)
    ursp.done |-> (st == ST_UNIT))
    else $error("unit finished while not awaited");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (load_res && adv_done) |=> (st == ST_IDLE))
    else $error("sequencer not idle after the last result");
`endif

endmodule

// ===== design/block_tridiagonal_cholesky_forward_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Block-tridiagonal Cholesky forward sweep unit
// Loads the coupling block, the precision block and the right-hand vector,
// and on a trigger runs one time step of the forward recursion in Q16.16.
// ----------------------------------------------------------------------------
// Load items without a trigger are accepted back to back. A triggered step
// reads each entry's base, then reads, multiplies and accumulates each
// product through the single multiply-accumulate path; the 4 roots and 30
// quotients go to the bit-serial unit unless the pivot is non-positive or
// the divisor zero. Each result is read from the store, then registered.
// Reset clears the valid bits of the precision and right-hand stores and
// marks the next step as the first of a sequence; no clearing pass is run.
module block_tridiagonal_cholesky_forward_unit import bcf_pkg::*; #(
  parameter int BLOCK_DIM = BLOCK_DIM_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // The working store holds seven regions of BLOCK_DIM*BLOCK_DIM entries:
  // precision block, right-hand vector, coupling block, factor L, LO (which
  // doubles as the previous step's LO), the forward solve y, and the mean
  // (which doubles as the previous step's mean).
  localparam int NN    = BLOCK_DIM * BLOCK_DIM;
  localparam int DEPTH = REGION_CNT * NN;
  localparam int VSPAN = CLEAR_REGIONS * NN;
  localparam int AW    = $clog2(DEPTH);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_clear;
  logic              mem_re0;
  logic [AW-1:0]     mem_raddr0;
  logic [DATA_W-1:0] mem_rdata0;
  logic              mem_re1;
  logic [AW-1:0]     mem_raddr1;
  logic [DATA_W-1:0] mem_rdata1;
  unit_req_t         ureq;
  unit_rsp_t         ursp;

  // The sequencer owns every store access, so a read and a write of the
  // same entry never overlap; it also holds the output register.
  bcf_ctrl #(
    .BLOCK_DIM (BLOCK_DIM)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_clear    (mem_clear),
    .mem_re0      (mem_re0),
    .mem_raddr0   (mem_raddr0),
    .mem_rdata0   (mem_rdata0),
    .mem_re1      (mem_re1),
    .mem_raddr1   (mem_raddr1),
    .mem_rdata1   (mem_rdata1),
    .ureq         (ureq),
    .ursp         (ursp)
  );

  bcf_mem #(
    .DEPTH (DEPTH),
    .VSPAN (VSPAN)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .we     (mem_we),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .clear  (mem_clear),
    .re0    (mem_re0),
    .raddr0 (mem_raddr0),
    .rdata0 (mem_rdata0),
    .re1    (mem_re1),
    .raddr1 (mem_raddr1),
    .rdata1 (mem_rdata1)
  );

  // One shared unit serves all square roots and divisions.
  bcf_divsqrt u_divsqrt (
    .clk (clk),
    .rst (rst),
    .req (ureq),
    .rsp (ursp)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the block-tridiagonal Cholesky forward sweep unit
// Loads coupling, precision and right-hand elements, triggers time steps,
// and checks every emitted L, LO and mean entry against a Q16.16 predictor
// of the forward recursion, under several sender and receiver idling modes.
// ----------------------------------------------------------------------------
module tb_top;
  import bcf_pkg::*;

  localparam int DIM = BLOCK_DIM_DEF;
  localparam int HOLD_CYCLES = 5000;

  // Predictor of the forward recursion plus the queue of expected entries.
  class cholesky_predictor;
    int coupling[DIM*DIM];
    int precision[DIM*DIM];
    int rhs[DIM];
    int lo_prev[DIM*DIM];
    int mean_prev[DIM];
    bit fresh_seq;
    result_t pending_entries[$];
    int mismatches;
    int steps;
    int checked;

    function new();
      foreach (coupling[i]) begin
        coupling[i] = 0; precision[i] = 0; lo_prev[i] = 0;
      end
      foreach (rhs[i]) begin
        rhs[i] = 0; mean_prev[i] = 0;
      end
      fresh_seq = 1;
      mismatches = 0;
      steps = 0;
      checked = 0;
    endfunction

    function int clip(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
    endfunction

    // Product rounded to Q16.16 by adding half an LSB and flooring.
    function longint rmul(int a, int b);
      longint p;
      p = longint'(a) * longint'(b);
      return (p + 32768) >>> 16;
    endfunction

    function int qdiv(int a, int b);
      if (b == 0) return 0;
      return clip((longint'(a) * 65536) / longint'(b));
    endfunction

    function int qroot(int a);
      longint unsigned x, r, b;
      x = {32'd0, a} << 16;
      r = 0;
      b = 64'd1 << 48;
      while (b > x) b = b >> 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x = x - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return int'(r);
    endfunction

    function void push_entry(logic [1:0] kind, int r, int c, int v);
      result_t e;
      e.result_kind = kind;
      e.out_row = r[IDX_W-1:0];
      e.out_col = c[IDX_W-1:0];
      e.result_value = v;
      e.pivot_error = 1'b0;
      e.last_of_run = 1'b0;
      pending_entries.push_back(e);
    endfunction

    function void run_time_step();
      int o[DIM*DIM];
      int cv[DIM];
      int l[DIM*DIM];
      int lo[DIM*DIM];
      int y[DIM];
      int m[DIM];
      bit bad_pivot;
      longint s;
      int d, base;
      o = precision;
      cv = rhs;
      bad_pivot = 0;
      base = pending_entries.size();
      // Fold in the previous step's coupling unless the sequence just began.
      if (!fresh_seq) begin
        for (int i = 0; i < DIM; i++) begin
          for (int j = 0; j <= i; j++) begin
            s = o[i*DIM+j];
            for (int k = 0; k < DIM; k++) s -= rmul(lo_prev[k*DIM+i], lo_prev[k*DIM+j]);
            o[i*DIM+j] = clip(s);
          end
          s = cv[i];
          for (int k = 0; k < DIM; k++) s -= rmul(coupling[i*DIM+k], mean_prev[k]);
          cv[i] = clip(s);
        end
      end
      foreach (l[i]) l[i] = 0;
      for (int j = 0; j < DIM; j++) begin
        s = o[j*DIM+j];
        for (int k = 0; k < j; k++) s -= rmul(l[j*DIM+k], l[j*DIM+k]);
        d = clip(s);
        if (d <= 0) begin
          bad_pivot = 1;
          d = 0;
        end else begin
          d = qroot(d);
        end
        l[j*DIM+j] = d;
        for (int i = j + 1; i < DIM; i++) begin
          s = o[i*DIM+j];
          for (int k = 0; k < j; k++) s -= rmul(l[i*DIM+k], l[j*DIM+k]);
          l[i*DIM+j] = qdiv(clip(s), d);
        end
      end
      for (int j = 0; j < DIM; j++)
        for (int i = 0; i < DIM; i++) begin
          s = coupling[i*DIM+j];
          for (int k = 0; k < i; k++) s -= rmul(l[i*DIM+k], lo[k*DIM+j]);
          lo[i*DIM+j] = qdiv(clip(s), l[i*DIM+i]);
        end
      for (int i = 0; i < DIM; i++) begin
        s = cv[i];
        for (int k = 0; k < i; k++) s -= rmul(l[i*DIM+k], y[k]);
        y[i] = qdiv(clip(s), l[i*DIM+i]);
      end
      for (int i = DIM - 1; i >= 0; i--) begin
        s = y[i];
        for (int k = i + 1; k < DIM; k++) s -= rmul(l[k*DIM+i], m[k]);
        m[i] = qdiv(clip(s), l[i*DIM+i]);
      end
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j <= i; j++) push_entry(KIND_FACTOR, i, j, l[i*DIM+j]);
      for (int i = 0; i < DIM; i++)
        for (int j = 0; j < DIM; j++) push_entry(KIND_LO, i, j, lo[i*DIM+j]);
      for (int i = 0; i < DIM; i++) push_entry(KIND_MEAN, i, 0, m[i]);
      for (int k = base; k < pending_entries.size(); k++)
        pending_entries[k].pivot_error = bad_pivot;
      pending_entries[pending_entries.size()-1].last_of_run = 1'b1;
      lo_prev = lo;
      mean_prev = m;
      foreach (precision[i]) precision[i] = 0;
      foreach (rhs[i]) rhs[i] = 0;
      fresh_seq = 0;
      steps++;
    endfunction

    function void note_item(item_t it);
      int r, c;
      r = it.row_index;
      c = it.col_index;
      case (it.req_type)
        REQ_COUPLING: if (r < DIM && c < DIM) coupling[r*DIM+c] = it.element_value;
        REQ_PRECISION: if (r < DIM && c < DIM) precision[r*DIM+c] = it.element_value;
        REQ_RHS: if (r < DIM) rhs[r] = it.element_value;
        default: fresh_seq = 1;
      endcase
      if (it.compute_now) run_time_step();
    endfunction

    function void check_result(result_t got);
      result_t want;
      checked++;
      if (pending_entries.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
        return;
      end
      want = pending_entries.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %p, actual %p", want, got);
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  cholesky_predictor pred = new();
  int idle_pct;
  int stall_pct;
  int hold_left;
  int items_in;

  block_tridiagonal_cholesky_forward_unit u_top (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Accepted items feed the predictor; accepted results are checked in order.
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) begin
      pred.note_item(item);
      items_in++;
    end
    if (!rst && result_valid && !result_stall) pred.check_result(result);
  end

  // Receiver: random stalls, or one long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      result_stall <= 1'b1;
      hold_left--;
    end else begin
      result_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Offers one item; the valid stays high into the next item unless a gap
  // is drawn, so it is never lowered and raised in the same step.
  task automatic send_item(logic [1:0] kind, int r, int c, int v, bit go);
    item_t it;
    it.req_type = kind;
    it.row_index = r[IDX_W-1:0];
    it.col_index = c[IDX_W-1:0];
    it.element_value = v;
    it.compute_now = go;
    if ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    item <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (item_stall);
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pred.pending_entries.size() != 0) @(posedge clk);
  endtask

  function automatic int diag_value();
    return $urandom_range(8 << 16, 1 << 16);
  endfunction

  function automatic int small_value();
    return int'($urandom_range(1 << 17)) - (1 << 16);
  endfunction

  // A well-formed time step: most precision and right-hand entries loaded in
  // random order of presence, the trigger riding on the last load.
  task automatic send_step();
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++)
        if ($urandom_range(9) < 8)
          send_item(REQ_PRECISION, i, j, (i == j) ? diag_value() : small_value(), 0);
    for (int i = 0; i < DIM - 1; i++)
      if ($urandom_range(3) != 0) send_item(REQ_RHS, i, $urandom_range(3), small_value(), 0);
    send_item(REQ_RHS, DIM - 1, $urandom_range(3), small_value(), 1);
  endtask

  // Noise: any field value, mostly without trigger.
  task automatic send_noise();
    send_item($urandom_range(3), $urandom_range(3), $urandom_range(3), $urandom,
              $urandom_range(7) == 0);
  endtask

  task automatic random_phase(int n_items);
    int target;
    target = items_in + n_items;
    while (items_in < target) begin
      case ($urandom_range(9))
        0, 1: send_noise();
        2: send_item(REQ_RESTART, $urandom_range(3), $urandom_range(3), $urandom, 0);
        3: send_item(REQ_COUPLING, $urandom_range(3), $urandom_range(3), small_value(), 0);
        default: send_step();
      endcase
    end
    wait_drained();
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    idle_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    items_in = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. The whole coupling block is written first, since no step
    // may read an unwritten coupling element.
    for (int i = 0; i < DIM; i++)
      for (int j = 0; j < DIM; j++)
        send_item(REQ_COUPLING, i, j, (i == 0 && j == 0) ? 32'sh7fffffff :
                  (i == 3 && j == 3) ? 32'sh80000000 : (i - j) * 32'sh8000, 0);
    // First step: largest diagonal, lowest right-hand value, zero pivots below.
    send_item(REQ_PRECISION, 0, 0, 32'sh7fffffff, 0);
    send_item(REQ_PRECISION, 1, 1, 32'sh10000, 0);
    send_item(REQ_RHS, 3, 3, 32'sh80000000, 1);
    // A restart that triggers a step at once, with a negative pivot.
    send_item(REQ_PRECISION, 0, 0, 32'sh80000000, 0);
    send_item(REQ_RESTART, 0, 0, 0, 1);
    // A later step on cleared stores, folding in the previous step.
    send_item(REQ_RHS, 0, 0, 0, 1);
    // Coupling back to moderate values for the random part.
    send_item(REQ_COUPLING, 0, 0, 32'sh4000, 0);
    send_item(REQ_COUPLING, 3, 3, -32'sh4000, 0);
    wait_drained();

    idle_pct = 0; stall_pct = 0;   random_phase(80);
    idle_pct = 83; stall_pct = 0;  random_phase(70);
    idle_pct = 0; stall_pct = 83;  random_phase(70);
    idle_pct = 35; stall_pct = 35; random_phase(70);

    // Long receiver hold-off while the sender keeps offering items, so the
    // unit fills up and stalls its input; then the sender waits for drain.
    idle_pct = 0; stall_pct = 0;
    hold_left = HOLD_CYCLES;
    send_step();
    for (int n = 0; n < 12; n++) send_noise();
    wait_drained();

    repeat (300) @(posedge clk);
    $display("Covered %0d items and %0d time steps, %0d result items checked.",
             items_in, pred.steps, pred.checked);
    $display("Idling modes: none, sender 83%%, receiver 83%%, both 35%%, long hold-off.");
    if (pred.mismatches == 0 && pred.pending_entries.size() == 0) begin
      $display("block_tridiagonal_cholesky_forward_unit: match");
    end else begin
      $display("%0d mismatches", pred.mismatches);
      $display("block_tridiagonal_cholesky_forward_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("timeout");
    $display("block_tridiagonal_cholesky_forward_unit: mismatch");
    $finish;
  end

endmodule
